/* rtl/ibus_frame_encoder_macros.svh */
// Assertion macros used by the iBUS frame encoder checker.
`ifndef IBUS_FRAME_ENCODER_MACROS_SVH
`define IBUS_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ife_pkg.sv */
// Shared types and constants of the iBUS frame encoder.
`default_nettype none

package ife_pkg;

  localparam int IFE_CHANNELS    = 14;
  localparam int IFE_MAX_RESULTS = 8;
  localparam int IFE_POS_W       = 4;

  localparam logic [7:0] HDR_FIRST  = 8'd32;
  localparam logic [7:0] HDR_SECOND = 8'd64;
  localparam logic [7:0] CR_BYTE    = 8'd13;

  // Byte slots of one item, in sending order.
  typedef enum logic [2:0] {
    SLOT_HDR_FIRST  = 3'd0,
    SLOT_HDR_SECOND = 3'd1,
    SLOT_VAL_LO     = 3'd2,
    SLOT_VAL_HI     = 3'd3,
    SLOT_CHK_LO     = 3'd4,
    SLOT_CHK_HI     = 3'd5
  } slot_e;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [15:0] value;
    logic [15:0] check;
    logic        hdr;
    logic        tail;
    logic        cr;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/ife_front.sv */
// Front part: accepts channel values, tracks frame position and checksum.
`default_nettype none

module ife_front #(
  parameter int CHANNELS = ife_pkg::IFE_CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] channel_value_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output ife_pkg::cmd_t    q_cmd_o
);
  import ife_pkg::*;

  logic [IFE_POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [15:0]          sum_q, sum_d, base, new_sum;
  logic                 cr_q;
  logic                 hdr, tail, accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the item and extend the running sum.
  always_comb begin
    hdr     = (pos_q == '0);
    base    = hdr ? ({8'd0, HDR_FIRST} + {8'd0, HDR_SECOND}) : sum_q;
    new_sum = base + {8'd0, channel_value_i[7:0]} + {8'd0, channel_value_i[15:8]};
    pos_inc = pos_q + 1'b1;
    tail    = (pos_inc == IFE_POS_W'(CHANNELS));
    pos_d   = tail ? '0 : pos_inc;
    sum_d   = tail ? '0 : new_sum;
  end

  assign q_push_o      = accept;
  assign q_cmd_o.value = channel_value_i;
  assign q_cmd_o.check = ~new_sum;
  assign q_cmd_o.hdr   = hdr;
  assign q_cmd_o.tail  = tail;
  assign q_cmd_o.cr    = cr_q;

  // Advance frame position on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Hold the carriage-return mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q <= 1'b0;
    end else if (cfg_we_i) begin
      cr_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/ife_queue.sv */
// Two-entry command queue between front and back.
`default_nettype none

module ife_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ife_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ife_pkg::cmd_t      cmd_o
);
  import ife_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Store pushed commands.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/ife_back.sv */
// Back part: serializes one command into bytes through an output register.
`default_nettype none

module ife_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire ife_pkg::cmd_t q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_item_o,
  output logic               end_of_frame_o
);
  import ife_pkg::*;

  logic       first_q;
  slot_e      slot_q, slot;
  logic       crph_q, crph;
  logic [2:0] cnt_q, cnt;
  slot_e      last_slot;
  logic [7:0] frame_byte, byte_d;
  logic       last, emit;
  logic       valid_q, last_q, eof_q;
  logic [7:0] byte_q;

  // Select the current slot and byte.
  always_comb begin
    slot = first_q ? (q_cmd_i.hdr ? SLOT_HDR_FIRST : SLOT_VAL_LO) : slot_q;
    crph = first_q ? 1'b0 : crph_q;
    cnt  = first_q ? 3'd0 : cnt_q;
    case (slot)
      SLOT_HDR_FIRST:  frame_byte = HDR_FIRST;
      SLOT_HDR_SECOND: frame_byte = HDR_SECOND;
      SLOT_VAL_LO:     frame_byte = q_cmd_i.value[7:0];
      SLOT_VAL_HI:     frame_byte = q_cmd_i.value[15:8];
      SLOT_CHK_LO:     frame_byte = q_cmd_i.check[7:0];
      SLOT_CHK_HI:     frame_byte = q_cmd_i.check[15:8];
      default:         frame_byte = 8'd0;
    endcase
    byte_d    = crph ? CR_BYTE : frame_byte;
    last_slot = q_cmd_i.tail ? SLOT_CHK_HI : SLOT_VAL_HI;
    last      = ((!q_cmd_i.cr || crph) && (slot == last_slot))
             || (cnt == 3'(IFE_MAX_RESULTS - 1));
  end

  assign emit    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = emit && last;

  // Step through the slots of the head command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      slot_q  <= SLOT_HDR_FIRST;
      crph_q  <= 1'b0;
      cnt_q   <= 3'd0;
    end else if (emit) begin
      first_q <= last;
      cnt_q   <= cnt + 3'd1;
      if (q_cmd_i.cr && !crph) begin
        crph_q <= 1'b1;
        slot_q <= slot;
      end else begin
        crph_q <= 1'b0;
        slot_q <= slot_e'(slot + 3'd1);
      end
    end
  end

  // Load the output register, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last;
      eof_q  <= last && q_cmd_i.tail;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_item_o = last_q;
  assign end_of_frame_o = eof_q;

endmodule

`default_nettype wire

/* rtl/ibus_frame_encoder.sv */
// Top level of the iBUS frame encoder.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i                cfg_data_i (interleave_cr)
//   in       in         in_valid_i/in_stall_o   channel_value_i[15:0]
//   out      out        out_valid_o/out_stall_i out_byte_o, last_of_item_o,
//                                               end_of_frame_o
//
// One output byte leaves per cycle from the back sequencer's output register
// while out_stall_i is low. An item has 2 bytes for a plain channel, 4 with
// header or checksum, 6 for both, doubled (up to 8) with CR bytes.
// Input is taken into a two-entry queue; the in stall rises only
// when the queue is full. Reset is asynchronous, needs no clearing pass, and
// starts a new frame. An out stall holds the byte and backs up into the queue.
`default_nettype none

module ibus_frame_encoder #(
  parameter int CHANNELS = ife_pkg::IFE_CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] channel_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_item_o,
  output logic             end_of_frame_o
);
  import ife_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, head_valid;

  ife_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .channel_value_i,
    .q_full_i (full),
    .q_push_o (push),
    .q_cmd_o  (push_cmd)
  );

  ife_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  ife_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (head_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .last_of_item_o,
    .end_of_frame_o
  );

endmodule

`default_nettype wire

/* rtl/ife_checker.sv */
// Port-level checker of the iBUS frame encoder and its bind.
`default_nettype none

`include "ibus_frame_encoder_macros.svh"

module ife_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic        cfg_data_i,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [15:0] channel_value_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_of_item_o,
  input wire logic        end_of_frame_o
);

  // A frame ends only on the final byte of an item.
  `IFE_ASSERT_IMP(a_eof_is_last, out_valid_o && end_of_frame_o, last_of_item_o, "eof without last")

  // Bytes of one item follow without a gap.
  `IFE_ASSERT_NXT(a_item_no_gap, out_valid_o && !out_stall_i && !last_of_item_o, out_valid_o, "gap inside item")

  // Hold a stalled byte.
  `IFE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(last_of_item_o) && $stable(end_of_frame_o), "stalled byte changed")

endmodule

bind ibus_frame_encoder ife_checker u_checker (.*);

`default_nettype wire
